// ===== rtl/bec_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bec_pkg
// Character classes, character codes and the classifier shared by the
// boolean expression syntax checker.
// ----------------------------------------------------------------------------
package bec_pkg;

    typedef logic [7:0] t_char;

    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_OPERAND = 3'd1,
        CLS_NOT     = 3'd2,
        CLS_BINOP   = 3'd3,
        CLS_OPEN    = 3'd4,
        CLS_CLOSE   = 3'd5,
        CLS_BAD     = 3'd7
    } t_class;

    // per-character verdict from the rule logic
    typedef struct packed {
        logic   err;
        t_class cls;
    } t_step;

    localparam t_char CHR_A     = 8'h41;
    localparam t_char CHR_Z     = 8'h5A;
    localparam t_char CHR_ZERO  = 8'h30;
    localparam t_char CHR_ONE   = 8'h31;
    localparam t_char CHR_NOT   = 8'h7E;
    localparam t_char CHR_OR    = 8'h7C;
    localparam t_char CHR_AND   = 8'h26;
    localparam t_char CHR_OPEN  = 8'h28;
    localparam t_char CHR_CLOSE = 8'h29;
    localparam t_char CHR_SPACE = 8'h20;

    function automatic t_class classify(input t_char c);
        t_class k;
        if ((c >= CHR_A && c <= CHR_Z) || c == CHR_ZERO || c == CHR_ONE) begin
            k = CLS_OPERAND;
        end else if (c == CHR_NOT) begin
            k = CLS_NOT;
        end else if (c == CHR_OR || c == CHR_AND) begin
            k = CLS_BINOP;
        end else if (c == CHR_OPEN) begin
            k = CLS_OPEN;
        end else if (c == CHR_CLOSE) begin
            k = CLS_CLOSE;
        end else begin
            k = CLS_BAD;
        end
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bec_char_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bec_char_if
// Valid/ready channel carrying one expression character and its end mark.
// ----------------------------------------------------------------------------
interface bec_char_if;
    logic           valid;
    logic           ready;
    bec_pkg::t_char char_code;
    logic           end_of_expression;

    modport source (output valid, output char_code, output end_of_expression, input ready);
    modport sink   (input valid, input char_code, input end_of_expression, output ready);
endinterface
`default_nettype wire

// ===== rtl/bec_verdict_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bec_verdict_if
// Valid/ready channel carrying the verdict for one expression.
// ----------------------------------------------------------------------------
interface bec_verdict_if;
    logic valid;
    logic ready;
    logic malformed;

    modport source (output valid, output malformed, input ready);
    modport sink   (input valid, input malformed, output ready);
endinterface
`default_nettype wire

// ===== rtl/bec_rule_check.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bec_rule_check
// Neighbor, character set and nesting rules for one character against the
// class of the previous non-space character and the current depth.
// ----------------------------------------------------------------------------
module bec_rule_check #(
    parameter int DEPTH_W   = 8,
    parameter int DEPTH_CAP = 255
) (
    input  bec_pkg::t_char         i_char,
    input  bec_pkg::t_class        i_cls,
    input  logic [DEPTH_W-1:0]     i_depth,
    output bec_pkg::t_step         o_step,
    output logic [DEPTH_W-1:0]     o_depth
);

    bec_pkg::t_class k;
    logic            prev_op;

    assign k       = bec_pkg::classify(i_char);
    assign prev_op = (i_cls == bec_pkg::CLS_NOT) || (i_cls == bec_pkg::CLS_BINOP);

    always_comb begin
        o_step.err = 1'b0;
        o_step.cls = i_cls;
        o_depth    = i_depth;
        // spaces leave everything alone
        if (i_char != bec_pkg::CHR_SPACE) begin
            if (k == bec_pkg::CLS_BAD) begin
                o_step.err = 1'b1;
            end else begin
                o_step.cls = k;
                if (prev_op && !(k == bec_pkg::CLS_NOT || k == bec_pkg::CLS_OPEN ||
                                 k == bec_pkg::CLS_OPERAND)) begin
                    o_step.err = 1'b1;
                end
                if (k == bec_pkg::CLS_BINOP &&
                    !(i_cls == bec_pkg::CLS_OPERAND || i_cls == bec_pkg::CLS_CLOSE)) begin
                    o_step.err = 1'b1;
                end
                if (k == bec_pkg::CLS_NOT &&
                    (i_cls == bec_pkg::CLS_OPERAND || i_cls == bec_pkg::CLS_CLOSE)) begin
                    o_step.err = 1'b1;
                end
                if (k == bec_pkg::CLS_OPERAND && i_cls == bec_pkg::CLS_OPERAND) begin
                    o_step.err = 1'b1;
                end
                if (k == bec_pkg::CLS_CLOSE) begin
                    if (i_depth == '0) begin
                        o_step.err = 1'b1;
                    end else begin
                        o_depth = i_depth - DEPTH_W'(1);
                    end
                end
                if (k == bec_pkg::CLS_OPEN) begin
                    if (i_depth >= DEPTH_W'(DEPTH_CAP)) begin
                        o_step.err = 1'b1;
                    end else begin
                        o_depth = i_depth + DEPTH_W'(1);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bool_expr_syntax_check_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bool_expr_syntax_check_core
// Streaming syntax checker for propositional formulas, one character a clock
// while the verdict output is not stalled.
// Characters enter on i_char, one item per clock when o_verdict is not
// stalled. Each character is registered, then checked in the next cycle by
// the rule logic against the kept class, depth and sticky error; the item
// that carries end_of_expression loads the verdict register from the
// stage register and sets o_verdict valid, and the checker state
// returns to its reset values for the next expression. Only a last
// character that meets a still-unread verdict waits. Nesting deeper than
// MAX_NESTING (capped at 255) counts as an error.
module bool_expr_syntax_check_core #(
    parameter int MAX_NESTING = 255
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    bec_char_if.sink          i_char,
    bec_verdict_if.source     o_verdict
);

    localparam int DEPTH_CAP = (MAX_NESTING < 255) ? MAX_NESTING : 255;
    localparam int DEPTH_W   = $clog2(DEPTH_CAP + 1);

    logic                 r_s1_valid, n_s1_valid;
    bec_pkg::t_char       r_s1_char;
    logic                 r_s1_last;
    bec_pkg::t_class      r_cls, n_cls;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic                 r_err, n_err;
    logic                 r_out_valid, n_out_valid;
    logic                 r_malformed, n_malformed;

    bec_pkg::t_step       step;
    logic [DEPTH_W-1:0]   step_depth;
    logic                 out_free, s1_fire, in_fire, final_err;

    bec_rule_check #(
        .DEPTH_W   (DEPTH_W),
        .DEPTH_CAP (DEPTH_CAP)
    ) u_rule (
        .i_char  (r_s1_char),
        .i_cls   (r_cls),
        .i_depth (r_depth),
        .o_step  (step),
        .o_depth (step_depth)
    );

    assign out_free     = !r_out_valid || o_verdict.ready;
    // only a last character needs room in the verdict register
    assign s1_fire      = r_s1_valid && (!r_s1_last || out_free);
    assign i_char.ready = !r_s1_valid || s1_fire;
    assign in_fire      = i_char.valid && i_char.ready;

    assign final_err = r_err || step.err || (step.cls == bec_pkg::CLS_NOT) ||
                       (step.cls == bec_pkg::CLS_BINOP) || (step_depth != '0);

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_cls       = r_cls;
        n_depth     = r_depth;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_malformed = r_malformed;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_fire) begin
            n_s1_valid = 1'b0;
        end
        if (o_verdict.ready) begin
            n_out_valid = 1'b0;
        end
        if (s1_fire) begin
            if (r_s1_last) begin
                n_cls       = bec_pkg::CLS_NONE;
                n_depth     = '0;
                n_err       = 1'b0;
                n_out_valid = 1'b1;
                n_malformed = final_err;
            end else begin
                n_cls   = step.cls;
                n_depth = step_depth;
                n_err   = r_err || step.err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_cls       <= bec_pkg::CLS_NONE;
            r_depth     <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_cls       <= n_cls;
            r_depth     <= n_depth;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_char <= i_char.char_code;
            r_s1_last <= i_char.end_of_expression;
        end
        r_malformed <= n_malformed;
    end

    assign o_verdict.valid     = r_out_valid;
    assign o_verdict.malformed = r_malformed;

`ifndef ASSERT_OFF
    a_depth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_W'(DEPTH_CAP))
        else $error("nesting depth above cap");

    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |=> (r_cls == bec_pkg::CLS_NONE && r_depth == '0 && !r_err))
        else $error("checker state not cleared after last character");

    a_verdict_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_last))
        else $error("verdict without a last character");
`endif

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives character streams into the boolean expression syntax checker and
// compares every verdict with one worked out from a behavioral model of the
// syntax rules kept alongside. Directed expressions cover each rule, then
// maximum nesting, then mostly well-formed random formulas with some
// corrupted ones and raw bytes. Random gaps and stalls are applied on both
// channels.
// ----------------------------------------------------------------------------
module tb;

    import bec_pkg::*;

    localparam int NEST_LIMIT = 255;
    localparam int NEST_CAP   = (NEST_LIMIT < 255) ? NEST_LIMIT : 255;

    typedef struct {
        t_char code;
        logic  eoe;
    } char_item_t;

    logic i_clk;
    logic i_rst_n;

    bec_char_if    char_ch ();
    bec_verdict_if verdict_ch ();

    bool_expr_syntax_check_core #(
        .MAX_NESTING(NEST_LIMIT)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_char   (char_ch),
        .o_verdict(verdict_ch)
    );

    char_item_t char_feed[$];
    t_char      expr_buf[$];
    logic       verdict_due[$];

    // checker state as seen from outside
    t_class      last_kind;
    int unsigned nest;
    logic        fault_seen;

    int          mismatches;
    int          chars_taken;
    int          chars_total;
    logic        char_took;
    char_item_t  cur_item;
    int          gap_left;
    int          calm_src;
    int          stall_left;
    int          calm_snk;
    logic        verdict_want;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic t_class char_kind(input t_char c);
        t_class k;
        case (c)
            CHR_ZERO, CHR_ONE: k = CLS_OPERAND;
            CHR_NOT:           k = CLS_NOT;
            CHR_OR, CHR_AND:   k = CLS_BINOP;
            CHR_OPEN:          k = CLS_OPEN;
            CHR_CLOSE:         k = CLS_CLOSE;
            default:           k = (c >= CHR_A && c <= CHR_Z) ? CLS_OPERAND : CLS_BAD;
        endcase
        return k;
    endfunction

    // advance the rule state by one accepted item, queue a verdict on the end mark
    task automatic check_char(input t_char c, input logic eoe);
        t_class k;
        logic   bad;
        if (c != CHR_SPACE) begin
            k   = char_kind(c);
            bad = 1'b0;
            if (k == CLS_BAD) begin
                bad = 1'b1;
            end else begin
                if ((last_kind == CLS_NOT || last_kind == CLS_BINOP) &&
                    !(k == CLS_NOT || k == CLS_OPEN || k == CLS_OPERAND)) begin
                    bad = 1'b1;
                end
                if (k == CLS_BINOP && !(last_kind == CLS_OPERAND || last_kind == CLS_CLOSE)) begin
                    bad = 1'b1;
                end
                if (k == CLS_NOT && (last_kind == CLS_OPERAND || last_kind == CLS_CLOSE)) begin
                    bad = 1'b1;
                end
                if (k == CLS_OPERAND && last_kind == CLS_OPERAND) begin
                    bad = 1'b1;
                end
                if (k == CLS_CLOSE) begin
                    if (nest == 0) bad = 1'b1;
                    else nest--;
                end
                if (k == CLS_OPEN) begin
                    if (nest >= NEST_CAP) bad = 1'b1;
                    else nest++;
                end
                last_kind = k;
            end
            if (bad) fault_seen = 1'b1;
        end
        if (eoe) begin
            verdict_due.push_back(fault_seen || last_kind == CLS_NOT ||
                                  last_kind == CLS_BINOP || nest != 0);
            last_kind  = CLS_NONE;
            nest       = 0;
            fault_seen = 1'b0;
        end
    endtask

    task automatic push_char(input t_char c, input logic eoe);
        char_item_t it;
        it.code = c;
        it.eoe  = eoe;
        char_feed.push_back(it);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(t_char'(s[i]), i == s.len() - 1);
        end
    endtask

    function automatic t_char rand_operand();
        int r;
        r = $urandom_range(0, 27);
        if (r == 26) return CHR_ZERO;
        if (r == 27) return CHR_ONE;
        return t_char'(CHR_A + r);
    endfunction

    function automatic t_char rand_token();
        t_char c;
        case ($urandom_range(0, 7))
            0: c = rand_operand();
            1: c = CHR_NOT;
            2: c = CHR_OR;
            3: c = CHR_AND;
            4: c = CHR_OPEN;
            5: c = CHR_CLOSE;
            6: c = CHR_SPACE;
            default: c = t_char'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // build a well-formed formula token by token into expr_buf
    task automatic gen_formula();
        int goal;
        int lvl;
        int max_lvl;
        int r;
        bit want_term;
        expr_buf.delete();
        goal      = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        max_lvl   = $urandom_range(0, 5);
        lvl       = 0;
        want_term = 1'b1;
        while (want_term || lvl > 0 || expr_buf.size() < goal) begin
            if (want_term) begin
                r = $urandom_range(0, 9);
                if (expr_buf.size() >= goal || r < 5 || (r >= 7 && lvl >= max_lvl)) begin
                    expr_buf.push_back(rand_operand());
                    want_term = 1'b0;
                end else if (r < 7) begin
                    expr_buf.push_back(CHR_NOT);
                end else begin
                    expr_buf.push_back(CHR_OPEN);
                    lvl++;
                    // empty group
                    if ($urandom_range(0, 7) == 0) begin
                        expr_buf.push_back(CHR_CLOSE);
                        lvl--;
                        want_term = 1'b0;
                    end
                end
            end else if (lvl > 0 && (expr_buf.size() >= goal || $urandom_range(0, 2) == 0)) begin
                expr_buf.push_back(CHR_CLOSE);
                lvl--;
            end else if ($urandom_range(0, 11) == 0 && lvl < max_lvl) begin
                // juxtaposed group
                expr_buf.push_back(CHR_OPEN);
                lvl++;
                want_term = 1'b1;
            end else begin
                expr_buf.push_back($urandom_range(0, 1) ? CHR_OR : CHR_AND);
                want_term = 1'b1;
            end
        end
    endtask

    task automatic corrupt_formula();
        int idx;
        if (expr_buf.size() > 0) begin
            idx = $urandom_range(0, expr_buf.size() - 1);
            case ($urandom_range(0, 2))
                0: expr_buf[idx] = t_char'($urandom_range(0, 255));
                1: expr_buf.delete(idx);
                default: expr_buf.insert(idx, rand_token());
            endcase
        end
    endtask

    // copy expr_buf to the feed with stray spaces, end mark on the final item
    task automatic flush_formula();
        bit tail_space;
        tail_space = (expr_buf.size() == 0) || ($urandom_range(0, 7) == 0);
        foreach (expr_buf[i]) begin
            if ($urandom_range(0, 9) == 0) push_char(CHR_SPACE, 1'b0);
            push_char(expr_buf[i], !tail_space && i == expr_buf.size() - 1);
        end
        if (tail_space) push_char(CHR_SPACE, 1'b1);
    endtask

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // verdict check and input acceptance, both sampled at the rising edge
    always @(posedge i_clk) begin
        char_took <= i_rst_n && char_ch.valid && char_ch.ready;
        if (i_rst_n) begin
            if (verdict_ch.valid && verdict_ch.ready) begin
                if (verdict_due.size() == 0) begin
                    flag_error($sformatf("verdict %0b with no expression pending",
                                         verdict_ch.malformed));
                end else begin
                    verdict_want = verdict_due.pop_front();
                    if (verdict_ch.malformed !== verdict_want) begin
                        flag_error($sformatf("malformed %b, expected %b",
                                             verdict_ch.malformed, verdict_want));
                    end
                end
            end
            if (char_ch.valid && char_ch.ready) begin
                check_char(char_ch.char_code, char_ch.end_of_expression);
                chars_taken++;
            end
        end
    end

    // character source
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (char_ch.valid && !char_took) begin
                // hold the item until taken
            end else if (gap_left > 0) begin
                char_ch.valid <= 1'b0;
                gap_left--;
            end else if (char_feed.size() > 0) begin
                cur_item = char_feed.pop_front();
                char_ch.char_code         <= cur_item.code;
                char_ch.end_of_expression <= cur_item.eoe;
                char_ch.valid             <= 1'b1;
                if (calm_src > 0) begin
                    calm_src--;
                    gap_left = 0;
                end else begin
                    gap_left = pick_idle();
                    if ($urandom_range(0, 49) == 0) calm_src = $urandom_range(20, 80);
                end
            end else begin
                char_ch.valid <= 1'b0;
            end
        end
    end

    // verdict sink
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_left > 0) begin
                verdict_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                verdict_ch.ready <= 1'b1;
                if (calm_snk > 0) begin
                    calm_snk--;
                end else begin
                    stall_left = pick_idle();
                    if ($urandom_range(0, 49) == 0) calm_snk = $urandom_range(20, 80);
                end
            end
        end
    end

    initial begin
        int r;
        i_rst_n                   = 1'b0;
        char_ch.valid             = 1'b0;
        char_ch.char_code         = '0;
        char_ch.end_of_expression = 1'b0;
        verdict_ch.ready          = 1'b0;
        last_kind   = CLS_NONE;
        nest        = 0;
        fault_seen  = 1'b0;
        mismatches  = 0;
        chars_taken = 0;
        char_took   = 1'b0;
        gap_left    = 0;
        calm_src    = 0;
        stall_left  = 0;
        calm_snk    = 0;

        // directed: well-formed and malformed short expressions
        push_text("~A&(Z|0)");
        push_text("1(B)");
        push_text(")");
        push_text("|A");
        push_text("A&");
        push_text("AB");
        push_text("A~B");
        push_text(" ");
        push_text("()");
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        push_text("(");

        // nesting exactly at the limit, then one level beyond it
        for (int n = 0; n < 2; n++) begin
            repeat (NEST_CAP + n) push_char(CHR_OPEN, 1'b0);
            repeat (NEST_CAP - 1) push_char(CHR_CLOSE, 1'b0);
            push_char(CHR_CLOSE, 1'b1);
        end

        // random: mostly well-formed, some corrupted, some raw bytes
        while (char_feed.size() < 1900) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                expr_buf.delete();
                repeat ($urandom_range(1, 8)) expr_buf.push_back(t_char'($urandom_range(0, 255)));
            end else begin
                gen_formula();
                if (r <= 5) repeat ($urandom_range(1, 2)) corrupt_formula();
            end
            flush_formula();
        end
        chars_total = char_feed.size();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (chars_taken != chars_total) @(posedge i_clk);
        while (verdict_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS bool_expr_syntax_check_core");
        end else begin
            $display("FAIL bool_expr_syntax_check_core");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("FAIL bool_expr_syntax_check_core");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bec_pkg.sv
rtl/bec_char_if.sv
rtl/bec_verdict_if.sv
rtl/bec_rule_check.sv
rtl/bool_expr_syntax_check_core.sv
dv/tb.sv
